// ===== hw/rtl/jts_pkg.sv =====
package jts_pkg;

    localparam int POSITION_BITS = 16;
    localparam int FIELD_BITS    = 16;
    localparam int SKIP_BITS     = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0]    LEN_MAX = {FIELD_BITS{1'b1}};

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_UP_E      = 8'h45;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_UP_N      = 8'h4E;
    localparam logic [7:0] CH_UP_T      = 8'h54;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LO_E      = 8'h65;
    localparam logic [7:0] CH_LO_F      = 8'h66;
    localparam logic [7:0] CH_LO_N      = 8'h6E;
    localparam logic [7:0] CH_LO_T      = 8'h74;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    typedef enum logic [3:0] {
        KIND_OBJ_BEGIN = 4'd0,
        KIND_OBJ_END   = 4'd1,
        KIND_ARR_BEGIN = 4'd2,
        KIND_ARR_END   = 4'd3,
        KIND_KEY       = 4'd4,
        KIND_STRING    = 4'd5,
        KIND_NUMBER    = 4'd6,
        KIND_NULL      = 4'd7,
        KIND_TRUE      = 4'd8,
        KIND_FALSE     = 4'd9,
        KIND_UNKNOWN   = 4'd10
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } out_item_t;

    // Results produced by one accepted byte, item0 first.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  item0;
        out_item_t  item1;
    } push_t;

    function automatic logic is_num_char(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_NINE], CH_LO_E, CH_UP_E, CH_MINUS, CH_PLUS, CH_DOT};
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_next(input logic [POSITION_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic logic [FIELD_BITS-1:0] len_next(input logic [FIELD_BITS-1:0] l);
        return (l == LEN_MAX) ? l : l + 1'b1;
    endfunction

    // Low bits of a position as carried in a token start field.
    function automatic logic [FIELD_BITS-1:0] to_start(input logic [POSITION_BITS-1:0] p);
        logic [POSITION_BITS+FIELD_BITS-1:0] wide;
        wide = {{FIELD_BITS{1'b0}}, p};
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/jts_scan_core.sv =====
module jts_scan_core
    import jts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output push_t      push
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_CLOSED,
        MODE_NUMBER,
        MODE_SKIP
    } mode_t;

    mode_t                    mode_reg,  mode_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next_v;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [FIELD_BITS-1:0]    pend_reg,  pend_next;
    logic [7:0]               prev_reg,  prev_next;
    logic [SKIP_BITS-1:0]     skip_reg,  skip_next;

    logic    first_v, second_v, do_fresh;
    result_t first_r, second_r;

    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        pend_next  = pend_reg;
        prev_next  = prev_reg;
        skip_next  = skip_reg;
        first_v    = 1'b0;
        first_r    = '{kind: KIND_UNKNOWN, start: '0, length: '0};
        second_v   = 1'b0;
        second_r   = '{kind: KIND_UNKNOWN, start: '0, length: '0};
        do_fresh   = 1'b0;

        // Work left over from the previous bytes.
        case (mode_reg)
            MODE_SKIP:
            begin
                if (skip_reg != '0)
                begin
                    skip_next = skip_reg - 1'b1;
                end
                if (skip_next == '0)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_STRING:
            begin
                if (in_byte == CH_QUOTE && prev_reg != CH_BACKSLASH)
                begin
                    if (is_last)
                    begin
                        first_v  = 1'b1;
                        first_r  = '{kind: KIND_STRING, start: to_start(pos_next(begin_reg)),
                                     length: pend_reg};
                    end
                    else
                    begin
                        mode_next = MODE_CLOSED;
                    end
                end
                else
                begin
                    pend_next = len_next(pend_reg);
                    prev_next = in_byte;
                    if (is_last)
                    begin
                        first_v = 1'b1;
                        first_r = '{kind: KIND_STRING, start: to_start(pos_next(begin_reg)),
                                    length: '0};
                    end
                end
            end
            MODE_CLOSED:
            begin
                // The string is a key only when a colon follows right away.
                first_v  = 1'b1;
                first_r  = '{kind: (in_byte == CH_COLON) ? KIND_KEY : KIND_STRING,
                             start: to_start(pos_next(begin_reg)), length: pend_reg};
                do_fresh = 1'b1;
            end
            MODE_NUMBER:
            begin
                if (is_num_char(in_byte))
                begin
                    pend_next = len_next(pend_reg);
                    if (is_last)
                    begin
                        first_v = 1'b1;
                        first_r = '{kind: KIND_NUMBER, start: to_start(begin_reg),
                                    length: pend_next};
                    end
                end
                else
                begin
                    first_v  = 1'b1;
                    first_r  = '{kind: KIND_NUMBER, start: to_start(begin_reg),
                                 length: pend_reg};
                    do_fresh = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // Scan the byte as the start of a new token.
        if (do_fresh)
        begin
            mode_next = MODE_IDLE;
            case (in_byte)
                CH_SPACE, CH_COLON, CH_COMMA:
                begin
                end
                CH_LBRACE:
                begin
                    second_v = 1'b1;
                    second_r = '{kind: KIND_OBJ_BEGIN, start: to_start(pos_reg), length: 16'd1};
                end
                CH_RBRACE:
                begin
                    second_v = 1'b1;
                    second_r = '{kind: KIND_OBJ_END, start: to_start(pos_reg), length: 16'd1};
                end
                CH_LBRACKET:
                begin
                    second_v = 1'b1;
                    second_r = '{kind: KIND_ARR_BEGIN, start: to_start(pos_reg), length: 16'd1};
                end
                CH_RBRACKET:
                begin
                    second_v = 1'b1;
                    second_r = '{kind: KIND_ARR_END, start: to_start(pos_reg), length: 16'd1};
                end
                CH_QUOTE:
                begin
                    if (is_last)
                    begin
                        second_v = 1'b1;
                        second_r = '{kind: KIND_STRING, start: to_start(pos_next(pos_reg)),
                                     length: '0};
                    end
                    else
                    begin
                        mode_next  = MODE_STRING;
                        begin_next = pos_reg;
                        pend_next  = '0;
                        prev_next  = CH_QUOTE;
                    end
                end
                CH_LO_N, CH_UP_N:
                begin
                    second_v  = 1'b1;
                    second_r  = '{kind: KIND_NULL, start: to_start(pos_reg), length: 16'd4};
                    mode_next = MODE_SKIP;
                    skip_next = 3'd3;
                end
                CH_LO_T, CH_UP_T:
                begin
                    second_v  = 1'b1;
                    second_r  = '{kind: KIND_TRUE, start: to_start(pos_reg), length: 16'd4};
                    mode_next = MODE_SKIP;
                    skip_next = 3'd3;
                end
                CH_LO_F, CH_UP_F:
                begin
                    second_v  = 1'b1;
                    second_r  = '{kind: KIND_FALSE, start: to_start(pos_reg), length: 16'd5};
                    mode_next = MODE_SKIP;
                    skip_next = 3'd4;
                end
                default:
                begin
                    second_v = 1'b1;
                    if (!is_num_char(in_byte))
                    begin
                        second_r = '{kind: KIND_UNKNOWN, start: to_start(pos_reg), length: '0};
                    end
                    else if (is_last)
                    begin
                        second_r = '{kind: KIND_NUMBER, start: to_start(pos_reg), length: 16'd1};
                    end
                    else
                    begin
                        second_v   = 1'b0;
                        mode_next  = MODE_NUMBER;
                        begin_next = pos_reg;
                        pend_next  = 16'd1;
                    end
                end
            endcase
        end

        // The last byte of a text returns everything to the reset state.
        if (is_last)
        begin
            mode_next  = MODE_IDLE;
            pos_next_v = '0;
            begin_next = '0;
            pend_next  = '0;
            prev_next  = '0;
            skip_next  = '0;
        end
        else
        begin
            pos_next_v = pos_next(pos_reg);
        end
    end

    // Pack the results so that the first one always sits in item0.
    always_comb
    begin
        push.count = {1'b0, first_v} + {1'b0, second_v};
        if (first_v)
        begin
            push.item0 = '{res: first_r, last: !second_v};
            push.item1 = '{res: second_r, last: 1'b1};
        end
        else
        begin
            push.item0 = '{res: second_r, last: 1'b1};
            push.item1 = '{res: second_r, last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            pend_reg  <= '0;
            prev_reg  <= '0;
            skip_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next_v;
            begin_reg <= begin_next;
            pend_reg  <= pend_next;
            prev_reg  <= prev_next;
            skip_reg  <= skip_next;
        end
    end

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_SKIP |-> skip_reg != '0)
        else $error("skip mode entered with nothing left to skip");

    a_last_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_last |=> pos_reg == '0 && mode_reg == MODE_IDLE)
        else $error("scanner state not cleared after the last byte");

    a_two_results_source: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (mode_reg == MODE_CLOSED || mode_reg == MODE_NUMBER))
        else $error("two results from a mode that can give only one");

endmodule

// ===== hw/rtl/jts_out_queue.sv =====
module jts_out_queue
    import jts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_en,
    input  push_t     push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic [1:0]              push_num;
    logic                    pop;

    // Room for the worst case of two results from one byte.
    assign room      = count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_num  = push_en ? push.count : 2'd0;
    assign count_next = count_reg + (QUEUE_AW+1)'(push_num) - (QUEUE_AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.item0;
        end
        if (push_num == 2'd2)
        begin
            mem[wr_ptr_reg + 1'b1] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(push_num);
            rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(pop);
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("output queue overflow");

    a_push_only_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_en && push.count != 2'd0 |-> room)
        else $error("results pushed without room in the output queue");

endmodule

// ===== hw/rtl/json_token_scanner_top.sv =====
// JSON token scanner.
// The input stream (s_tvalid/s_tready/s_tdata/s_tlast) carries one byte of
// JSON text per transfer; s_tlast marks the final byte of a text and flushes
// any open token. The output stream (m_tvalid/m_tready/m_tdata/m_tlast)
// carries one token per transfer: kind, start position and length, with
// m_tlast set on the last token caused by a given input byte.
// Each byte is scanned in the cycle it is taken, and its tokens are written
// into a four-entry output queue, from whose head they are offered.
// The block takes one byte every cycle while s_tready is high; a byte can
// cause up to two tokens, and s_tready stays high while the queue has room
// for two. The output side therefore sets the sustained rate: one byte per
// cycle as long as the receiver takes one token per cycle and bytes give
// one token on average. When the receiver stalls, tokens collect in the
// queue and s_tready drops as soon as fewer than two entries are free;
// bytes that cause no token keep flowing until then, and no token is lost.
// Reset empties the queue and sets the scanner idle at byte position zero.
// After the last byte of a text the position also returns to zero.
module json_token_scanner_top
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
                                   // [35:20] token_length, [39:36] zero
    output logic        m_tlast    // last_of_run
);

    logic      step;
    push_t     push;
    out_item_t head;

    assign step = s_tvalid && s_tready;

    jts_scan_core u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (s_tdata),
        .is_last (s_tlast),
        .push    (push)
    );

    jts_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (step),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = {4'b0000, head.res.length, head.res.start, head.res.kind};
    assign m_tlast = head.last;

endmodule
